@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define VN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define VN_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/vn2d_pkg.sv @@
package vn2d_pkg;

	localparam logic [31:0] HASH_MUL_X    = 32'h8da6b343;
	localparam logic [31:0] HASH_MUL_Y    = 32'hd8163841;
	localparam logic [31:0] HASH_MUL_SEED = 32'h9e3779b9;
	localparam logic [31:0] HASH_MUL_MIX  = 32'h85ebca6b;
	localparam int unsigned HASH_SHIFT_A  = 13;
	localparam int unsigned HASH_SHIFT_B  = 16;
	localparam logic [23:0] CORNER_MAX    = 24'hffffff;
	localparam logic [15:0] NOISE_MAX     = 16'hffff;

	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;
	localparam int unsigned BACK_STAGES = 6;

	typedef struct packed {
		logic [31:0] cell_x;
		logic [31:0] cell_y;
		logic [15:0] frac_x;
		logic [15:0] frac_y;
	} front_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ hw/rtl/vn2d_front.sv @@
module vn2d_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           x_coord,
	input  logic [31:0]           y_coord,
	input  vn2d_pkg::q_status_t   q_status,
	output logic                  q_push,
	output vn2d_pkg::front_item_t q_din
);

	localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;

	vn2d_pkg::front_item_t item_q;
	vn2d_pkg::front_item_t split;
	logic                  valid_q;
	logic                  accept;

	always_comb begin
		split.cell_x = 32'($signed(x_coord) >>> FRAC_BITS);
		split.cell_y = 32'($signed(y_coord) >>> FRAC_BITS);
		split.frac_x = 16'(((x_coord & FRAC_MASK) >> SH_R) << SH_L);
		split.frac_y = 16'(((y_coord & FRAC_MASK) >> SH_R) << SH_L);
	end

	assign q_push   = valid_q && !q_status.full;
	assign in_stall = valid_q && q_status.full;
	assign accept   = in_valid && !in_stall;
	assign q_din    = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= accept || (valid_q && !q_push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= split;
		end
	end

endmodule

@@ hw/rtl/vn2d_queue.sv @@
module vn2d_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vn2d_pkg::front_item_t din,
	input  logic                  pop,
	output vn2d_pkg::front_item_t dout,
	output vn2d_pkg::q_status_t   status
);

	vn2d_pkg::front_item_t mem_q [vn2d_pkg::QDEPTH];
	logic [vn2d_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [vn2d_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [vn2d_pkg::QCNT_W-1:0] cnt_q;

	assign status.full  = (cnt_q == vn2d_pkg::QCNT_W'(vn2d_pkg::QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign dout         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ hw/rtl/vn2d_back.sv @@
module vn2d_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           seed,
	input  vn2d_pkg::front_item_t q_item,
	input  vn2d_pkg::q_status_t   q_status,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           noise_value
);

	logic        adv;
	logic [5:0]  v_q;

	logic [31:0] hx0, hx1, hy0, hy1, hs;
	logic [31:0] h_s1 [4];
	logic [31:0] ffx_s1, ffy_s1;
	logic [15:0] fx_s1, fy_s1;

	logic [31:0] m_s2 [4];
	logic [31:0] ffx_s2, ffy_s2;
	logic [47:0] fffx_s2, fffy_s2;

	logic [23:0] c_s3 [4];
	logic [15:0] ux_s3, uy_s3;
	logic [50:0] vx, vy;

	logic [40:0] row0_s4, row1_s4;
	logic [15:0] uy_s4;
	logic [16:0] wx0;

	logic [56:0] acc_s5;
	logic [16:0] wy0;

	logic [40:0] a_div;
	logic [16:0] q0;
	logic [24:0] rem;
	logic [16:0] quo;
	logic [15:0] noise_s6;

	assign adv         = !v_q[5] || !out_stall;
	assign q_pop       = adv && !q_status.empty;
	assign out_valid   = v_q[5];
	assign noise_value = noise_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[4:0], !q_status.empty};
		end
	end

	always_comb begin
		hx0 = 32'(q_item.cell_x * vn2d_pkg::HASH_MUL_X);
		hx1 = 32'((q_item.cell_x + 32'd1) * vn2d_pkg::HASH_MUL_X);
		hy0 = 32'(q_item.cell_y * vn2d_pkg::HASH_MUL_Y);
		hy1 = 32'((q_item.cell_y + 32'd1) * vn2d_pkg::HASH_MUL_Y);
		hs  = 32'(seed * vn2d_pkg::HASH_MUL_SEED);
	end

	always_comb begin
		vx  = 51'({ffx_s2, 16'b0}) + 51'({ffx_s2, 17'b0}) - 51'({fffx_s2, 1'b0});
		vy  = 51'({ffy_s2, 16'b0}) + 51'({ffy_s2, 17'b0}) - 51'({fffy_s2, 1'b0});
		wx0 = 17'h10000 - 17'(ux_s3);
		wy0 = 17'h10000 - 17'(uy_s4);
	end

	always_comb begin
		a_div = acc_s5[56:16];
		q0    = a_div[40:24];
		rem   = 25'(a_div[23:0]) + 25'(q0);
		quo   = (rem >= 25'(vn2d_pkg::CORNER_MAX)) ? q0 + 17'd1 : q0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1[0] <= hx0 ^ hy0 ^ hs;
			h_s1[1] <= hx1 ^ hy0 ^ hs;
			h_s1[2] <= hx0 ^ hy1 ^ hs;
			h_s1[3] <= hx1 ^ hy1 ^ hs;
			ffx_s1  <= 32'(q_item.frac_x) * 32'(q_item.frac_x);
			ffy_s1  <= 32'(q_item.frac_y) * 32'(q_item.frac_y);
			fx_s1   <= q_item.frac_x;
			fy_s1   <= q_item.frac_y;

			for (int i = 0; i < 4; i++) begin
				m_s2[i] <= 32'((h_s1[i] ^ (h_s1[i] >> vn2d_pkg::HASH_SHIFT_A))
					* vn2d_pkg::HASH_MUL_MIX);
			end
			ffx_s2  <= ffx_s1;
			ffy_s2  <= ffy_s1;
			fffx_s2 <= 48'(ffx_s1) * 48'(fx_s1);
			fffy_s2 <= 48'(ffy_s1) * 48'(fy_s1);

			for (int i = 0; i < 4; i++) begin
				c_s3[i] <= 24'(m_s2[i] ^ (m_s2[i] >> vn2d_pkg::HASH_SHIFT_B));
			end
			ux_s3 <= vx[47:32];
			uy_s3 <= vy[47:32];

			row0_s4 <= 41'(c_s3[0]) * 41'(wx0) + 41'(c_s3[1]) * 41'(ux_s3);
			row1_s4 <= 41'(c_s3[2]) * 41'(wx0) + 41'(c_s3[3]) * 41'(ux_s3);
			uy_s4   <= uy_s3;

			acc_s5 <= 57'(row0_s4) * 57'(wy0) + 57'(row1_s4) * 57'(uy_s4);

			noise_s6 <= quo[16] ? vn2d_pkg::NOISE_MAX : quo[15:0];
		end
	end

endmodule

@@ hw/rtl/value_noise_2d_core.sv @@
// Path: input register, 4-entry queue, 6-stage hash/fade/blend pipeline.
// Throughput: one request per cycle while out_stall is low; a held result stops
// the pipeline, fills the queue and then raises in_stall.
// Reset: arst_n clears the seed, all valid flags and the queue at once; no
// clearing pass follows.
module value_noise_2d_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] noise_value
);

	logic [31:0]           seed_q;
	vn2d_pkg::q_status_t   q_status;
	vn2d_pkg::front_item_t q_din;
	vn2d_pkg::front_item_t q_dout;
	logic                  q_push;
	logic                  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	vn2d_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.q_status (q_status),
		.q_push   (q_push),
		.q_din    (q_din)
	);

	vn2d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.status (q_status)
	);

	vn2d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.q_item      (q_dout),
		.q_status    (q_status),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.noise_value (noise_value)
	);

endmodule

@@ hw/rtl/vn2d_checker.sv @@
`include "assert_macros.svh"

module vn2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] noise_value
);

	localparam int unsigned CAP = 1 + vn2d_pkg::QDEPTH + vn2d_pkg::BACK_STAGES;

	logic [3:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 4'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	`VN_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(noise_value), "stalled result changed")
	`VN_ASSERT_NEVER(a_no_phantom, clk, arst_n, out_valid && pend_q == 4'd0, "result without pending request")
	`VN_ASSERT_NEVER(a_bound, clk, arst_n, pend_q > 4'(CAP), "too many requests in flight")
	`VN_ASSERT(a_full_stall, clk, arst_n, pend_q == 4'(CAP) |-> in_stall, "full block did not stall input")

endmodule

bind value_noise_2d_core vn2d_checker u_chk (.*);
